[rtl/ssd_pkg.sv]
// Package for the seven-segment value display scanner.
// Holds the queue item type, the control states, the display codes and the
// divide-by-ten helper. It depends on nothing.
`default_nettype none

package ssd_pkg;

    localparam int DIGITS = 8;
    localparam int IDX_W  = $clog2(DIGITS);
    localparam int SEL_W  = 3;
    localparam int CODE_W = 5;
    localparam int MAG_W  = 32;
    localparam int FRAC_W = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    localparam logic [CODE_W-1:0] CODE_BLANK = CODE_W'(21);
    localparam logic [CODE_W-1:0] CODE_MINUS = CODE_W'(20);
    localparam logic [CODE_W-1:0] POINT_ADD  = CODE_W'(10);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGITS - 1);

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_TICK = 1'b1
    } req_kind_t;

    typedef struct packed {
        req_kind_t          kind;
        logic               negative;
        logic [MAG_W-1:0]   mag;
        logic [FRAC_W-1:0]  frac;
        logic               point;
    } ssd_item_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_CONV = 1'b1
    } ssd_state_t;

    typedef struct packed {
        logic [MAG_W-1:0] quot;
        logic [3:0]       rem;
    } div10_t;

    // Quotient by the reciprocal 0xCCCCCCCD with a shift of 35, exact for
    // every 32-bit unsigned value; the remainder follows by shift and add.
    function automatic div10_t div10(input logic [MAG_W-1:0] x);
        logic [2*MAG_W-1:0] prod;
        logic [MAG_W-1:0]   q;
        logic [MAG_W-1:0]   q10;
        logic [MAG_W-1:0]   diff;
        div10_t             res;
        prod = {{MAG_W{1'b0}}, x} * {{MAG_W{1'b0}}, 32'hCCCC_CCCD};
        q    = {3'b000, prod[2*MAG_W-1:35]};
        q10  = (q << 3) + (q << 1);
        diff = x - q10;
        res.quot = q;
        res.rem  = diff[3:0];
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/ssd_front.sv]
// Front part of the display scanner: accepts requests, classifies them and
// splits off sign and magnitude, then holds them in a two-entry queue.
// Depends on ssd_pkg.
`default_nettype none

module ssd_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [ssd_pkg::IN_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tuser,
    output logic                               q_valid,
    output ssd_pkg::ssd_item_t                 q_item,
    input  wire logic                          q_pop
);
    import ssd_pkg::*;

    ssd_item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]       count_reg, count_next;
    ssd_item_t             new_item;
    logic [MAG_W-1:0]      raw;
    logic                  push;

    assign raw = s_tdata[MAG_W-1:0];

    always_comb begin
        new_item.kind     = req_kind_t'(s_tuser);
        new_item.negative = raw[MAG_W-1];
        new_item.mag      = raw[MAG_W-1] ? (MAG_W'(0) - raw) : raw;
        new_item.frac     = s_tdata[MAG_W +: FRAC_W];
        new_item.point    = s_tdata[MAG_W + FRAC_W];
    end

    assign s_tready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (q_pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

`default_nettype wire

[rtl/ssd_back.sv]
// Back part of the display scanner: converts loads into digit codes with one
// divide-by-ten step per cycle, and answers scan ticks from the code buffer.
// Depends on ssd_pkg.
`default_nettype none

module ssd_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            q_valid,
    input  wire ssd_pkg::ssd_item_t              q_item,
    output logic                                 q_pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [ssd_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import ssd_pkg::*;

    ssd_state_t            state_reg, state_next;
    logic [CODE_W-1:0]     code_reg [DIGITS];
    logic [MAG_W-1:0]      mag_reg, mag_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      scan_reg, scan_next;
    logic [FRAC_W-1:0]     frac_reg, frac_next;
    logic                  point_reg, point_next;
    logic                  minus_reg, minus_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                  buf_we;
    logic [CODE_W-1:0]     buf_wdata;
    logic                  want_digit;
    logic                  out_free;
    div10_t                dv;

    assign dv         = div10(mag_reg);
    assign out_free   = !out_valid_reg || m_tready;
    assign want_digit = (mag_reg != '0) || (idx_reg == '0)
                        || (point_reg && (32'(idx_reg) <= 32'(frac_reg)));

    always_comb begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        idx_next       = idx_reg;
        scan_next      = scan_reg;
        frac_next      = frac_reg;
        point_next     = point_reg;
        minus_next     = minus_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        buf_we         = 1'b0;
        buf_wdata      = CODE_BLANK;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_item.kind == REQ_LOAD) begin
                        q_pop      = 1'b1;
                        mag_next   = q_item.mag;
                        minus_next = q_item.negative;
                        frac_next  = q_item.frac;
                        point_next = q_item.point;
                        idx_next   = '0;
                        state_next = ST_CONV;
                    end else if (out_free) begin
                        q_pop          = 1'b1;
                        out_valid_next = 1'b1;
                        out_data_next  = {code_reg[scan_reg], SEL_W'(scan_reg)};
                        scan_next      = (scan_reg == LAST_IDX) ? '0 : scan_reg + 1'b1;
                    end
                end
            end
            ST_CONV: begin
                buf_we = 1'b1;
                if (want_digit) begin
                    buf_wdata = {1'b0, dv.rem};
                    if (point_reg && (32'(idx_reg) == 32'(frac_reg))) begin
                        buf_wdata = {1'b0, dv.rem} + POINT_ADD;
                    end
                end else if (minus_reg) begin
                    buf_wdata  = CODE_MINUS;
                    minus_next = 1'b0;
                end
                mag_next = dv.quot;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DIGITS; i++) begin
                code_reg[i] <= CODE_BLANK;
            end
        end else begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
            if (buf_we) begin
                code_reg[idx_reg] <= buf_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg      <= mag_next;
        idx_reg      <= idx_next;
        frac_reg     <= frac_next;
        point_reg    <= point_next;
        minus_reg    <= minus_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

[rtl/seven_segment_value_display_scanner_top.sv]
// Top level of the seven-segment value display scanner.
// Connects the request front part and the conversion back part.
// Depends on ssd_pkg, ssd_front and ssd_back.
//
// Requests enter on the s_ stream; s_tuser selects a load (0) or a scan
// tick (1). A load carries a signed value, the point position and a point
// flag; it yields no result and rewrites the eight-entry digit code buffer.
// A tick yields one result on the m_ stream: the current scan position and
// the code stored there, after which the position advances with wrap.
// Requests pass through a two-entry queue, so until it is full the input
// side keeps taking requests while the back part converts or a result waits.
// A load holds the back part while it is taken from the queue and then while
// the eight digits are made, one shared divide-by-ten step each. A tick's
// result is registered and shows in the cycle after the tick leaves the queue,
// so ticks can stream at one per cycle while results are taken and no load runs.
// When the receiver stalls, the result holds in the output register and
// further ticks wait in the queue; loads ahead of them still proceed.
// Reset fills the buffer with blank codes and returns the scan position to 0.
`default_nettype none

module seven_segment_value_display_scanner_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // Bits from low: value[31:0], fraction_digits[34:32], show_point[35].
    input  wire logic [ssd_pkg::IN_TDATA_W-1:0]   s_tdata,
    // Bit 0: req_type.
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // Bits from low: digit_select[2:0], digit_code[7:3].
    output logic [ssd_pkg::OUT_TDATA_W-1:0]       m_tdata
);
    import ssd_pkg::*;

    logic      q_valid;
    logic      q_pop;
    ssd_item_t q_item;

    ssd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    ssd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

[tb/sv/seven_segment_value_display_scanner_top_test.sv]
// Self-checking testbench for the seven-segment value display scanner.
// Drives load and scan tick requests on the s_ stream, predicts every scan result
// with a model of the digit code buffer, and checks the m_ stream against it.
// Depends on ssd_pkg and seven_segment_value_display_scanner_top.
`default_nettype none

module seven_segment_value_display_scanner_top_test;

    import ssd_pkg::*;

    typedef struct packed {
        req_kind_t         kind;
        logic [MAG_W-1:0]  value;
        logic [FRAC_W-1:0] frac;
        logic              point;
    } display_req_t;

    typedef struct packed {
        logic [SEL_W-1:0]  sel;
        logic [CODE_W-1:0] code;
    } scan_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    display_req_t pending_reqs[$];
    display_req_t active_req;
    scan_result_t expected_scans[$];

    logic [CODE_W-1:0] shown_codes [DIGITS];
    logic [IDX_W-1:0]  scan_idx;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int load_count = 0;
    int tick_count = 0;
    int checked_count = 0;

    seven_segment_value_display_scanner_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("seven_segment_value_display_scanner_top_test failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 50) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    task automatic load_display(input logic [MAG_W-1:0] value, input logic [FRAC_W-1:0] frac,
                                input logic point);
        logic             negative;
        logic             minus_pending;
        logic             want_digit;
        logic [MAG_W-1:0] mag;
        negative = value[MAG_W-1];
        mag = negative ? (32'd0 - value) : value;
        minus_pending = negative;
        for (int i = 0; i < DIGITS; i++) begin
            want_digit = (mag != 0) || (i == 0) || (point && (i <= int'(frac)));
            if (want_digit) begin
                shown_codes[i] = CODE_W'(mag % 32'd10);
            end else if (minus_pending) begin
                shown_codes[i] = CODE_MINUS;
                minus_pending = 1'b0;
            end else begin
                shown_codes[i] = CODE_BLANK;
            end
            mag = mag / 32'd10;
        end
        // A plain digit is below the point offset; only such a digit takes the point.
        if (point && int'(frac) < DIGITS && shown_codes[frac] < POINT_ADD) begin
            shown_codes[frac] = shown_codes[frac] + POINT_ADD;
        end
    endtask

    task automatic accept_request(input display_req_t r);
        if (r.kind == REQ_LOAD) begin
            load_display(r.value, r.frac, r.point);
            load_count++;
        end else begin
            expected_scans.push_back('{sel: SEL_W'(scan_idx), code: shown_codes[scan_idx]});
            scan_idx = (scan_idx == LAST_IDX) ? '0 : scan_idx + 1'b1;
            tick_count++;
        end
    endtask

    function automatic display_req_t random_request();
        display_req_t r;
        int unsigned  ndigits;
        int unsigned  limit;
        int unsigned  mag;
        r.kind  = REQ_TICK;
        r.value = $urandom;
        r.frac  = FRAC_W'($urandom_range(7));
        r.point = 1'($urandom_range(1));
        if ($urandom_range(99) < 30) begin
            r.kind = REQ_LOAD;
            case ($urandom_range(9))
                0: r.value = '0;
                1: r.value = 32'h8000_0000;
                2: r.value = 32'h7FFF_FFFF;
                3: r.value = $urandom;
                default: begin
                    ndigits = $urandom_range(9, 1);
                    limit = 1;
                    repeat (ndigits) limit = limit * 10;
                    mag = $urandom_range(limit - 1, 0);
                    r.value = $urandom_range(1) ? (32'd0 - mag) : mag;
                end
            endcase
        end
        return r;
    endfunction

    task automatic queue_load(input logic [MAG_W-1:0] value, input logic [FRAC_W-1:0] frac,
                              input logic point);
        pending_reqs.push_back('{kind: REQ_LOAD, value: value, frac: frac, point: point});
    endtask

    task automatic queue_ticks(input int count);
        repeat (count) begin
            pending_reqs.push_back('{kind: REQ_TICK, value: $urandom,
                                     frac: FRAC_W'($urandom_range(7)),
                                     point: 1'($urandom_range(1))});
        end
    endtask

    always @(posedge aclk) begin : drive_requests
        logic next_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                accept_request(active_req);
                next_valid = 1'b0;
            end
            if (!next_valid && pending_reqs.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                active_req = pending_reqs.pop_front();
                s_tdata <= {4'b0000, active_req.point, active_req.frac, active_req.value};
                s_tuser <= active_req.kind;
                next_valid = 1'b1;
            end
            s_tvalid <= next_valid;
        end
    end

    always @(posedge aclk) begin : check_results
        scan_result_t      want;
        logic [SEL_W-1:0]  got_sel;
        logic [CODE_W-1:0] got_code;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_sel  = m_tdata[SEL_W-1:0];
                got_code = m_tdata[SEL_W+CODE_W-1:SEL_W];
                checked_count++;
                if (expected_scans.size() == 0) begin
                    report_mismatch($sformatf("unexpected result select %0d code %0d",
                                              got_sel, got_code));
                end else begin
                    want = expected_scans.pop_front();
                    if (got_sel != want.sel) begin
                        report_mismatch($sformatf("digit_select %0d, expected %0d",
                                                  got_sel, want.sel));
                    end
                    if (got_code != want.code) begin
                        report_mismatch($sformatf("digit_code %0d, expected %0d at select %0d",
                                                  got_code, want.code, want.sel));
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin : run_test
        int           idle_by_phase  [4];
        int           stall_by_phase [4];
        scan_result_t leftover;
        idle_by_phase  = '{0, 69, 0, 30};
        stall_by_phase = '{0, 0, 69, 30};
        for (int i = 0; i < DIGITS; i++) begin
            shown_codes[i] = CODE_BLANK;
        end
        scan_idx = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset contents first, then zero, the most negative value, zero fill with a
        // minus above it, the largest value with the point on the top digit.
        queue_ticks(3);
        queue_load(32'd0, 3'd0, 1'b0);
        queue_ticks(5);
        queue_load(32'h8000_0000, 3'd3, 1'b0);
        queue_ticks(4);
        queue_load(32'hFFFF_FFFB, 3'd2, 1'b1);
        queue_ticks(4);
        queue_load(32'h7FFF_FFFF, 3'd7, 1'b1);
        queue_ticks(4);

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_by_phase[p];
            recv_stall_pct = stall_by_phase[p];
            repeat (425) pending_reqs.push_back(random_request());
            while (pending_reqs.size() != 0 || s_tvalid || expected_scans.size() != 0) begin
                @(negedge aclk);
            end
        end
        repeat (40) @(negedge aclk);

        while (expected_scans.size() != 0) begin
            leftover = expected_scans.pop_front();
            report_mismatch($sformatf("missing result select %0d code %0d",
                                      leftover.sel, leftover.code));
        end

        $display("Sent %0d loads and %0d scan ticks over four idle and stall phases.",
                 load_count, tick_count);
        $display("Checked %0d scan results; %0d mismatches.", checked_count, error_count);
        if (error_count == 0) begin
            $display("seven_segment_value_display_scanner_top_test passed");
        end else begin
            $display("seven_segment_value_display_scanner_top_test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/ssd_pkg.sv
rtl/ssd_front.sv
rtl/ssd_back.sv
rtl/seven_segment_value_display_scanner_top.sv
tb/sv/seven_segment_value_display_scanner_top_test.sv
